FILE: sv/fvp_pkg.sv
// fvp_pkg: shared types and constants for the value-purge fifo
// used by fvp_cell and fifo_with_value_purge; no dependencies

package fvp_pkg;

    localparam int DEPTH_DEFAULT = 32;
    localparam int DATA_W        = 8;
    localparam int CNT_OUT_W     = 6;

    typedef enum logic [1:0] {
        REQ_PUSH  = 2'd0,
        REQ_POP   = 2'd1,
        REQ_PURGE = 2'd2,
        REQ_NOP   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PURGE,
        S_DONE
    } state_t;

    typedef struct packed {
        logic shift_en;
        logic match_en;
        logic load_en;
    } cell_ctrl_t;

endpackage

FILE: sv/fvp_cell.sv
// fvp_cell: one entry of the shifting queue
// depends on fvp_pkg (cell_ctrl_t, DATA_W)

module fvp_cell
(
    input  logic                              clk,
    input  fvp_pkg::cell_ctrl_t               ctrl,
    input  logic                              valid,
    input  logic signed [fvp_pkg::DATA_W-1:0] key,
    input  logic                              shift_in,
    input  logic signed [fvp_pkg::DATA_W-1:0] nbr_data,
    input  logic signed [fvp_pkg::DATA_W-1:0] load_data,
    output logic signed [fvp_pkg::DATA_W-1:0] data,
    output logic                              shift_out
);

    logic signed [fvp_pkg::DATA_W-1:0] data_reg;
    logic signed [fvp_pkg::DATA_W-1:0] data_next;
    logic                              match;

    assign match     = ctrl.match_en & valid & (data_reg == key);
    assign shift_out = shift_in | match;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.load_en)
        begin
            data_next = load_data;
        end
        else if (ctrl.shift_en && shift_out)
        begin
            data_next = nbr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

FILE: sv/fifo_with_value_purge.sv
// fifo_with_value_purge: shifting fifo of signed 8-bit entries with purge by value
// depends on fvp_pkg and fvp_cell
//
// A request word is accepted only while the block is idle and the response
// register is free or being drained. Push, pop and the unused kind go through
// the done state, which loads the response registers; the next word is not
// taken until the done state has passed. A purge removes one matching entry per
// cycle through the cell chain and goes to the done state once it finds no
// further match. A stalled response holds off the next request. Each cell holds
// one entry; a removal moves every entry behind the first match one cell forward
// in the same cycle. No clearing pass after reset.

module fifo_with_value_purge
#(
    parameter int QUEUE_DEPTH = fvp_pkg::DEPTH_DEFAULT
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  logic [1:0]                        req_type,
    input  logic signed [fvp_pkg::DATA_W-1:0] operand_value,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output logic signed [fvp_pkg::DATA_W-1:0] front_value,
    output logic [fvp_pkg::CNT_OUT_W-1:0]     entry_count,
    output logic [fvp_pkg::CNT_OUT_W-1:0]     removed_count,
    output logic [1:0]                        status_code
);

    localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int DW      = fvp_pkg::DATA_W;
    localparam int OW      = fvp_pkg::CNT_OUT_W;

    fvp_pkg::state_t  state_reg, state_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] removed_reg, removed_next;
    fvp_pkg::status_t status_reg, status_next;
    logic signed [DW-1:0] key_reg, key_next;

    logic                 rsp_valid_reg, rsp_valid_next;
    logic signed [DW-1:0] front_reg, front_next;
    logic [COUNT_W-1:0]   rsp_count_reg, rsp_count_next;
    logic [COUNT_W-1:0]   rsp_removed_reg, rsp_removed_next;
    fvp_pkg::status_t     rsp_status_reg, rsp_status_next;

    logic                 accept;
    logic                 any_match;
    logic                 shift_en;
    logic                 match_en;
    logic                 push_en;
    logic                 pop_head;
    logic signed [DW-1:0] cell_key;

    logic signed [DW-1:0] cell_data [QUEUE_DEPTH];
    logic                 chain     [QUEUE_DEPTH+1];

    assign req_stall = !((state_reg == fvp_pkg::S_IDLE) && (!rsp_valid_reg || !rsp_stall));
    assign accept    = req_valid & ~req_stall;
    assign any_match = chain[QUEUE_DEPTH];
    assign chain[0]  = pop_head;
    assign cell_key  = (state_reg == fvp_pkg::S_PURGE) ? key_reg : operand_value;

    // cell row
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        fvp_pkg::cell_ctrl_t  ctrl;
        logic signed [DW-1:0] nbr;

        assign ctrl.shift_en = shift_en;
        assign ctrl.match_en = match_en;
        assign ctrl.load_en  = push_en && (count_reg == COUNT_W'(i));

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign nbr = '0;
        end
        else
        begin : g_mid
            assign nbr = cell_data[i+1];
        end

        fvp_cell u_cell
        (
            .clk       (clk),
            .ctrl      (ctrl),
            .valid     (COUNT_W'(i) < count_reg),
            .key       (cell_key),
            .shift_in  (chain[i]),
            .nbr_data  (nbr),
            .load_data (operand_value),
            .data      (cell_data[i]),
            .shift_out (chain[i+1])
        );
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fvp_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (req_type == fvp_pkg::REQ_PURGE)
                    begin
                        state_next = fvp_pkg::S_PURGE;
                    end
                    else
                    begin
                        state_next = fvp_pkg::S_DONE;
                    end
                end
            end
            fvp_pkg::S_PURGE:
            begin
                if (!any_match)
                begin
                    state_next = fvp_pkg::S_DONE;
                end
            end
            fvp_pkg::S_DONE:
            begin
                state_next = fvp_pkg::S_IDLE;
            end
            default:
            begin
                state_next = fvp_pkg::S_IDLE;
            end
        endcase
    end

    // datapath control
    always_comb
    begin
        count_next       = count_reg;
        removed_next     = removed_reg;
        status_next      = status_reg;
        key_next         = key_reg;
        shift_en         = 1'b0;
        match_en         = 1'b0;
        push_en          = 1'b0;
        pop_head         = 1'b0;
        rsp_valid_next   = rsp_valid_reg && rsp_stall;
        front_next       = front_reg;
        rsp_count_next   = rsp_count_reg;
        rsp_removed_next = rsp_removed_reg;
        rsp_status_next  = rsp_status_reg;

        unique case (state_reg)
            fvp_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    removed_next = '0;
                    status_next  = fvp_pkg::ST_OK;
                    key_next     = operand_value;
                    unique case (req_type)
                        fvp_pkg::REQ_PUSH:
                        begin
                            if (count_reg == COUNT_W'(QUEUE_DEPTH))
                            begin
                                status_next = fvp_pkg::ST_FULL;
                            end
                            else
                            begin
                                push_en    = 1'b1;
                                count_next = count_reg + COUNT_W'(1);
                            end
                        end
                        fvp_pkg::REQ_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = fvp_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                shift_en     = 1'b1;
                                pop_head     = 1'b1;
                                count_next   = count_reg - COUNT_W'(1);
                                removed_next = COUNT_W'(1);
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            fvp_pkg::S_PURGE:
            begin
                shift_en = 1'b1;
                match_en = 1'b1;
                if (any_match)
                begin
                    count_next   = count_reg - COUNT_W'(1);
                    removed_next = removed_reg + COUNT_W'(1);
                end
                else if (removed_reg == '0)
                begin
                    status_next = fvp_pkg::ST_NOT_FOUND;
                end
            end
            fvp_pkg::S_DONE:
            begin
                rsp_valid_next   = 1'b1;
                front_next       = (count_reg == '0) ? '0 : cell_data[0];
                rsp_count_next   = count_reg;
                rsp_removed_next = removed_reg;
                rsp_status_next  = status_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fvp_pkg::S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        removed_reg     <= removed_next;
        status_reg      <= status_next;
        key_reg         <= key_next;
        front_reg       <= front_next;
        rsp_count_reg   <= rsp_count_next;
        rsp_removed_reg <= rsp_removed_next;
        rsp_status_reg  <= rsp_status_next;
    end

    assign rsp_valid   = rsp_valid_reg;
    assign front_value = front_reg;
    assign status_code = rsp_status_reg;

    if (COUNT_W >= OW)
    begin : g_cnt_trunc
        assign entry_count   = rsp_count_reg[OW-1:0];
        assign removed_count = rsp_removed_reg[OW-1:0];
    end
    else
    begin : g_cnt_ext
        assign entry_count   = {{(OW-COUNT_W){1'b0}}, rsp_count_reg};
        assign removed_count = {{(OW-COUNT_W){1'b0}}, rsp_removed_reg};
    end

endmodule
